FILE: src/assert_macros.svh
// Assertion macros shared by the sorter RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, checked only while out of reset.
`define BAS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked property, checked during reset too.
`define BAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BAS_ASSERT(lbl, clk, rstn, prop, msg)
`define BAS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/bas_pkg.sv
// Shared types and constants for the byte array sorter.
// No dependencies.
package bas_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VAL_W     = 8;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef struct packed {
        t_val value;
        logic last;
    } t_in_item;

    typedef struct packed {
        t_val sorted_value;
        logic final_res;
        logic overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLD,
        S_PIV,
        S_RRD,
        S_RCMP,
        S_LRD,
        S_LCMP,
        S_SWAP,
        S_FRD,
        S_FWR,
        S_DEC,
        S_POP,
        S_POPW,
        S_EMIT_RD,
        S_EMIT
    } t_state;

endpackage

FILE: src/bas_store.sv
// Element store: one write port, one registered read port.
// Depends on bas_pkg.
module bas_store
    import bas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_val                     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_val                     o_rdata
);

    t_val r_mem [DEPTH];
    t_val r_rdata;

    // Write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bas_stack.sv
// Range stack memory holding pending (low, high) index pairs.
// Depends on bas_pkg for the default depth.
module bas_stack
    import bas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int W     = 2 * $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Push writes, pop reads, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bas_ctrl.sv
// Sequencer: load, quicksort partition loop with one shared compare, emit.
// Depends on bas_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bas_ctrl
    import bas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  t_in_item                     i_item,
    output logic                         o_busy,
    output logic                         o_valid,
    output t_out_item                    o_result,
    // element store port
    output logic                         o_st_we,
    output logic [$clog2(DEPTH)-1:0]     o_st_waddr,
    output t_val                         o_st_wdata,
    output logic [$clog2(DEPTH)-1:0]     o_st_raddr,
    input  t_val                         i_st_rdata,
    // range stack port
    output logic                         o_sk_we,
    output logic [$clog2(DEPTH)-1:0]     o_sk_waddr,
    output logic [2*$clog2(DEPTH)-1:0]   o_sk_wdata,
    output logic [$clog2(DEPTH)-1:0]     o_sk_raddr,
    input  logic [2*$clog2(DEPTH)-1:0]   i_sk_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 1;
    localparam logic [CW-1:0] SP_MAX = CW'(DEPTH);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic            r_drop, n_drop;
    logic [CW-1:0]   r_sp, n_sp;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;
    logic [CW-1:0]   r_n, n_n;
    logic [AW-1:0]   r_lo, n_lo;
    logic [AW-1:0]   r_hi, n_hi;
    logic [AW-1:0]   r_l, n_l;
    logic [AW-1:0]   r_r, n_r;
    logic [AW-1:0]   r_k, n_k;
    t_val            r_pivot, n_pivot;
    t_val            r_vr, n_vr;
    t_val            r_vl, n_vl;

    logic            accept;
    logic            room;
    logic [CW-1:0]   fill_next;
    logic            l_lt_r;
    logic            rd_gt_piv;
    logic            left_big;
    logic            right_big;
    logic            left_small;
    logic            is_final;

    assign accept    = i_start && (r_state == S_IDLE);
    assign room      = (r_fill < SP_MAX);
    assign fill_next = room ? r_fill + CW'(1) : r_fill;
    assign l_lt_r    = (r_l < r_r);
    // shared compare against the pivot
    assign rd_gt_piv = (i_st_rdata > r_pivot);
    // subranges [lo, p-1] and [p+1, hi] with p = l; sort only ranges of two or more
    assign left_big   = (IW'(r_lo) + IW'(1)) < IW'(r_l);
    assign right_big  = (IW'(r_l) + IW'(1)) < IW'(r_hi);
    assign left_small = (r_l - r_lo) < (r_hi - r_l);
    assign is_final   = (r_k == AW'(r_n - CW'(1)));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_item.last) begin
                    n_state = (fill_next > CW'(1)) ? S_PLD : S_EMIT_RD;
                end
            end
            S_PLD:  n_state = S_PIV;
            S_PIV:  n_state = S_RRD;
            S_RRD:  n_state = l_lt_r ? S_RCMP : S_FRD;
            S_RCMP: n_state = rd_gt_piv ? S_RRD : S_LRD;
            S_LRD:  n_state = l_lt_r ? S_LCMP : S_FRD;
            S_LCMP: n_state = rd_gt_piv ? S_SWAP : S_LRD;
            S_SWAP: n_state = S_RRD;
            S_FRD:  n_state = S_FWR;
            S_FWR:  n_state = S_DEC;
            S_DEC: begin
                if (left_small) begin
                    n_state = left_big ? S_PLD : S_POP;
                end else begin
                    n_state = right_big ? S_PLD : S_POP;
                end
            end
            S_POP:     n_state = (r_sp == '0) ? S_EMIT_RD : S_POPW;
            S_POPW:    n_state = S_PLD;
            S_EMIT_RD: n_state = S_EMIT;
            S_EMIT:    n_state = is_final ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and outputs
    always_comb begin
        n_fill      = r_fill;
        n_drop      = r_drop;
        n_sp        = r_sp;
        n_out_valid = 1'b0;
        n_out       = r_out;
        n_n         = r_n;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_l         = r_l;
        n_r         = r_r;
        n_k         = r_k;
        n_pivot     = r_pivot;
        n_vr        = r_vr;
        n_vl        = r_vl;
        o_st_we     = 1'b0;
        o_st_waddr  = r_l;
        o_st_wdata  = r_pivot;
        o_st_raddr  = r_l;
        o_sk_we     = 1'b0;
        o_sk_waddr  = r_sp[AW-1:0];
        o_sk_wdata  = {r_lo, r_hi};
        o_sk_raddr  = AW'(r_sp - CW'(1));
        unique case (r_state)
            S_IDLE: begin
                // store the transfer, or drop it when full
                if (accept) begin
                    o_st_waddr = r_fill[AW-1:0];
                    o_st_wdata = i_item.value;
                    if (room) begin
                        o_st_we = 1'b1;
                        n_fill  = fill_next;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_item.last) begin
                        n_n  = fill_next;
                        n_lo = '0;
                        n_hi = AW'(fill_next - CW'(1));
                        n_sp = '0;
                    end
                end
            end
            S_PLD: begin
                o_st_raddr = r_lo;
            end
            S_PIV: begin
                n_pivot = i_st_rdata;
                n_l     = r_lo;
                n_r     = r_hi;
            end
            S_RRD: begin
                o_st_raddr = r_r;
            end
            S_RCMP: begin
                // right scan: step down past larger elements
                if (rd_gt_piv) begin
                    n_r = r_r - AW'(1);
                end else begin
                    n_vr = i_st_rdata;
                end
            end
            S_LRD: begin
                o_st_raddr = r_l;
            end
            S_LCMP: begin
                // left scan: step up, or start the swap of l and r
                if (rd_gt_piv) begin
                    n_vl       = i_st_rdata;
                    o_st_we    = 1'b1;
                    o_st_waddr = r_l;
                    o_st_wdata = r_vr;
                end else begin
                    n_l = r_l + AW'(1);
                end
            end
            S_SWAP: begin
                o_st_we    = 1'b1;
                o_st_waddr = r_r;
                o_st_wdata = r_vl;
            end
            S_FRD: begin
                o_st_raddr = r_l;
            end
            S_FWR: begin
                // move the meeting element to the range head
                o_st_we    = 1'b1;
                o_st_waddr = r_lo;
                o_st_wdata = i_st_rdata;
            end
            S_DEC: begin
                // drop the pivot into place, push the larger side, go on with the smaller
                o_st_we    = 1'b1;
                o_st_waddr = r_l;
                o_st_wdata = r_pivot;
                if (left_small) begin
                    o_sk_wdata = {r_l + AW'(1), r_hi};
                    if (right_big && (r_sp < SP_MAX)) begin
                        o_sk_we = 1'b1;
                        n_sp    = r_sp + CW'(1);
                    end
                    n_hi = r_l - AW'(1);
                end else begin
                    o_sk_wdata = {r_lo, r_l - AW'(1)};
                    if (left_big && (r_sp < SP_MAX)) begin
                        o_sk_we = 1'b1;
                        n_sp    = r_sp + CW'(1);
                    end
                    n_lo = r_l + AW'(1);
                end
            end
            S_POP: begin
                if (r_sp != '0) begin
                    n_sp = r_sp - CW'(1);
                end
            end
            S_POPW: begin
                n_lo = i_sk_rdata[2*AW-1:AW];
                n_hi = i_sk_rdata[AW-1:0];
            end
            S_EMIT_RD: begin
                o_st_raddr = '0;
                n_k        = '0;
            end
            S_EMIT: begin
                // one result per cycle, read ahead by one
                o_st_raddr            = r_k + AW'(1);
                n_k                   = r_k + AW'(1);
                n_out_valid           = 1'b1;
                n_out.sorted_value    = i_st_rdata;
                n_out.final_res       = is_final;
                n_out.overflow        = r_drop;
                if (is_final) begin
                    n_fill = '0;
                    n_drop = 1'b0;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_n     <= n_n;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_l     <= n_l;
        r_r     <= n_r;
        r_k     <= n_k;
        r_pivot <= n_pivot;
        r_vr    <= n_vr;
        r_vl    <= n_vl;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `BAS_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= SP_MAX, "range stack pointer overrun")
    `BAS_ASSERT(a_scan_order, i_clk, i_rst_n, (r_state == S_RRD || r_state == S_RCMP || r_state == S_LRD || r_state == S_LCMP) |-> (r_l <= r_r), "scan indices crossed")
    `BAS_ASSERT(a_last_busy, i_clk, i_rst_n, (i_start && !o_busy && i_item.last) |=> o_busy, "last transfer did not start the sort")
    `BAS_ASSERT(a_emit_burst, i_clk, i_rst_n, (r_out_valid && !r_out.final_res) |=> r_out_valid, "gap inside a result burst")
    `BAS_ASSERT(a_final_end, i_clk, i_rst_n, (r_out_valid && r_out.final_res) |=> !r_out_valid, "result after the final one")

endmodule

FILE: src/byte_array_sorter_core.sv
// Top level of the byte array sorter: sequencer, element store, range stack.
// Depends on bas_pkg, bas_ctrl, bas_store and bas_stack.
//
//   Channel  | Handshake                       | Payload
//   ---------+---------------------------------+---------------------------
//   input    | start high while busy low       | i_item   (t_in_item)
//   result   | o_valid strobe, one cycle each  | o_result (t_out_item)
//
// Loading accepts one transfer per cycle and does not raise busy. A transfer with
// last set starts the sort, whose compares share the single store read port.
// Results follow one per cycle once the range stack is empty, read in S_EMIT_RD
// and registered out of S_EMIT; busy drops in the cycle that shows the final
// result. The receiver cannot stall.
module byte_array_sorter_core
    import bas_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int AW = $clog2(DEPTH);

    logic            st_we;
    logic [AW-1:0]   st_waddr;
    t_val            st_wdata;
    logic [AW-1:0]   st_raddr;
    t_val            st_rdata;
    logic            sk_we;
    logic [AW-1:0]   sk_waddr;
    logic [2*AW-1:0] sk_wdata;
    logic [AW-1:0]   sk_raddr;
    logic [2*AW-1:0] sk_rdata;

    // Sequencer with the shared compare
    bas_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .o_st_we    (st_we),
        .o_st_waddr (st_waddr),
        .o_st_wdata (st_wdata),
        .o_st_raddr (st_raddr),
        .i_st_rdata (st_rdata),
        .o_sk_we    (sk_we),
        .o_sk_waddr (sk_waddr),
        .o_sk_wdata (sk_wdata),
        .o_sk_raddr (sk_raddr),
        .i_sk_rdata (sk_rdata)
    );

    // Element store
    bas_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Range stack
    bas_stack #(
        .DEPTH (DEPTH),
        .W     (2 * AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (sk_wdata),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

endmodule
